>>> rtl/mbbf_pkg.sv
// shared constants for the mouse button bounce filter
package mbbf_pkg;

    // default sizing
    localparam int BUTTONS_DEF   = 3;
    localparam int TIME_BITS_DEF = 16;

    // fixed field widths
    localparam int HOLD_W   = 16;
    localparam int BTN_W    = 2;
    localparam int ACTION_W = 2;
    localparam int ENABLE_W = 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int TDATA_W  = 8;

    // buttons the filter logic knows about
    localparam int FILTER_BUTTONS = 3;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd3;

    // register indexes (address bits [3:2])
    localparam logic [1:0] REG_SHORT  = 2'd0;
    localparam logic [1:0] REG_HOLD   = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    // register reset values
    localparam logic [HOLD_W-1:0]   SHORT_RST  = 16'd80;
    localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd70;
    localparam logic [ENABLE_W-1:0] ENABLE_RST = 3'd1;

endpackage

>>> rtl/mouse_button_bounce_filter_unit.sv
// mouse button bounce filter: release hold with press cancel, stream in and out
// words pass from the pending word bundle through the output register to the master side
// throughput: one item per cycle while each item makes at most one word and m_tready
//   holds; an item making k words (tick or flush paying back k releases) stalls the
//   input until the single output register has drained the pending word bundle
// reset: all button state cleared, registers back to short 80, hold 70, enable 1
module mouse_button_bounce_filter_unit #(
    parameter int BUTTONS   = mbbf_pkg::BUTTONS_DEF,
    parameter int TIME_BITS = mbbf_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mbbf_pkg::TDATA_W-1:0]  s_tdata,   // [1:0] button, rest zero
    input  logic [mbbf_pkg::ACTION_W-1:0] s_tuser,   // [1:0] action
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbbf_pkg::TDATA_W-1:0]  m_tdata,   // [1:0] out_button, rest zero
    output logic [1:0]                    m_tuser,   // [0] is_release, [1] delayed
    output logic                          m_tlast,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbbf_pkg::ADDR_W-1:0]   paddr,
    input  logic [mbbf_pkg::DATA_W-1:0]   pwdata,
    output logic [mbbf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CMP_W = (TIME_BITS > mbbf_pkg::HOLD_W) ? TIME_BITS : mbbf_pkg::HOLD_W;

    // configuration registers
    logic [mbbf_pkg::HOLD_W-1:0]   short_reg;
    logic [mbbf_pkg::HOLD_W-1:0]   hold_ticks_reg;
    logic [mbbf_pkg::ENABLE_W-1:0] enable_reg;

    // per-button state
    logic [BUTTONS-1:0]          held_reg, held_next;
    logic [BUTTONS-1:0]          seen_reg, seen_next;
    logic [BUTTONS-1:0]          withheld_reg, withheld_next;
    logic [TIME_BITS-1:0]        since_reg [BUTTONS];
    logic [TIME_BITS-1:0]        since_next [BUTTONS];
    logic [mbbf_pkg::HOLD_W-1:0] left_reg [BUTTONS];
    logic [mbbf_pkg::HOLD_W-1:0] left_next [BUTTONS];

    // pending word bundle: one plain event or a mask of paid-back releases
    logic                       ev_valid_reg, ev_valid_next;
    logic [mbbf_pkg::BTN_W-1:0] ev_button_reg, ev_button_next;
    logic                       ev_release_reg, ev_release_next;
    logic [BUTTONS-1:0]         pay_mask_reg, pay_mask_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [mbbf_pkg::BTN_W-1:0] out_button_reg, out_button_next;
    logic                       out_release_reg, out_release_next;
    logic                       out_delayed_reg, out_delayed_next;
    logic                       out_last_reg, out_last_next;

    logic                          cfg_write;
    logic                          in_accept;
    logic                          out_free;
    logic                          pending;
    logic                          take_last;
    logic [BUTTONS-1:0]            low_bit;
    logic [BUTTONS-1:0]            mask_rest;
    logic [IDX_W-1:0]              low_idx;
    logic [mbbf_pkg::ACTION_W-1:0] action;
    logic [mbbf_pkg::BTN_W-1:0]    btn_in;
    logic [3:0]                    enable_ext;
    logic                          filtered;

    assign action     = s_tuser;
    assign btn_in     = s_tdata[mbbf_pkg::BTN_W-1:0];
    assign enable_ext = {1'b0, enable_reg};
    assign filtered   = (int'(btn_in) < BUTTONS) && (int'(btn_in) < mbbf_pkg::FILTER_BUTTONS)
                        && enable_ext[btn_in];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            mbbf_pkg::REG_SHORT:  prdata = {16'd0, short_reg};
            mbbf_pkg::REG_HOLD:   prdata = {16'd0, hold_ticks_reg};
            mbbf_pkg::REG_ENABLE: prdata = {29'd0, enable_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg      <= mbbf_pkg::SHORT_RST;
            hold_ticks_reg <= mbbf_pkg::HOLD_RST;
            enable_reg     <= mbbf_pkg::ENABLE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                mbbf_pkg::REG_SHORT:  short_reg      <= pwdata[15:0];
                mbbf_pkg::REG_HOLD:   hold_ticks_reg <= pwdata[15:0];
                mbbf_pkg::REG_ENABLE: enable_reg     <= pwdata[2:0];
                default:              ;
            endcase
        end
    end

    // drain control: lowest paid-back button goes first
    assign pending   = ev_valid_reg || (|pay_mask_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign low_bit   = pay_mask_reg & (~pay_mask_reg + BUTTONS'(1));
    assign mask_rest = pay_mask_reg & ~low_bit;
    assign take_last = out_free && pending && (ev_valid_reg || (mask_rest == '0));
    assign s_tready  = !pending || take_last;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        low_idx = '0;
        for (int b = BUTTONS - 1; b >= 0; b--)
        begin
            if (pay_mask_reg[b])
                low_idx = IDX_W'(b);
        end
    end

    // output register next value
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_button_next  = out_button_reg;
        out_release_next = out_release_reg;
        out_delayed_next = out_delayed_reg;
        out_last_next    = out_last_reg;
        if (out_free)
        begin
            out_valid_next = pending;
            if (ev_valid_reg)
            begin
                out_button_next  = ev_button_reg;
                out_release_next = ev_release_reg;
                out_delayed_next = 1'b0;
                out_last_next    = 1'b1;
            end
            else
            begin
                out_button_next  = mbbf_pkg::BTN_W'(low_idx);
                out_release_next = 1'b1;
                out_delayed_next = 1'b1;
                out_last_next    = (mask_rest == '0);
            end
        end
    end

    // item processing and bundle update
    always_comb
    begin
        held_next       = held_reg;
        seen_next       = seen_reg;
        withheld_next   = withheld_reg;
        since_next      = since_reg;
        left_next       = left_reg;
        ev_valid_next   = ev_valid_reg;
        ev_button_next  = ev_button_reg;
        ev_release_next = ev_release_reg;
        pay_mask_next   = pay_mask_reg;

        // words moved to the output register leave the bundle
        if (out_free && pending)
        begin
            if (ev_valid_reg)
                ev_valid_next = 1'b0;
            else
                pay_mask_next = mask_rest;
        end

        if (in_accept)
        begin
            ev_valid_next   = 1'b0;
            ev_button_next  = btn_in;
            ev_release_next = (action == mbbf_pkg::ACT_RELEASE);
            pay_mask_next   = '0;
            case (action)
                // tick: age presses, count down withheld releases
                mbbf_pkg::ACT_TICK:
                begin
                    for (int b = 0; b < BUTTONS; b++)
                    begin
                        if (seen_reg[b] && (since_reg[b] != '1))
                            since_next[b] = since_reg[b] + TIME_BITS'(1);
                        if (withheld_reg[b])
                        begin
                            if (left_reg[b] <= mbbf_pkg::HOLD_W'(1))
                            begin
                                withheld_next[b] = 1'b0;
                                left_next[b]     = '0;
                                held_next[b]     = 1'b0;
                                pay_mask_next[b] = 1'b1;
                            end
                            else
                            begin
                                left_next[b] = left_reg[b] - mbbf_pkg::HOLD_W'(1);
                            end
                        end
                    end
                end
                // flush: pay back every withheld release, clear all state
                mbbf_pkg::ACT_FLUSH:
                begin
                    pay_mask_next = withheld_reg;
                    held_next     = '0;
                    seen_next     = '0;
                    withheld_next = '0;
                    for (int b = 0; b < BUTTONS; b++)
                    begin
                        since_next[b] = '0;
                        left_next[b]  = '0;
                    end
                end
                default:
                begin
                    if (!filtered)
                    begin
                        // disabled or unknown button passes through
                        ev_valid_next = 1'b1;
                    end
                    else
                    begin
                        for (int b = 0; b < BUTTONS; b++)
                        begin
                            if (int'(btn_in) == b)
                            begin
                                if (action == mbbf_pkg::ACT_PRESS)
                                begin
                                    if (withheld_reg[b])
                                    begin
                                        withheld_next[b] = 1'b0;
                                        left_next[b]     = '0;
                                    end
                                    else if (!held_reg[b])
                                    begin
                                        held_next[b]  = 1'b1;
                                        ev_valid_next = 1'b1;
                                    end
                                    seen_next[b]  = 1'b1;
                                    since_next[b] = '0;
                                end
                                else if (!held_reg[b])
                                begin
                                    ev_valid_next = 1'b1;
                                end
                                else if (seen_reg[b] &&
                                         (CMP_W'(since_reg[b]) < CMP_W'(short_reg)))
                                begin
                                    withheld_next[b] = 1'b1;
                                    left_next[b]     = hold_ticks_reg;
                                end
                                else
                                begin
                                    held_next[b]  = 1'b0;
                                    ev_valid_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    // state, bundle and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            seen_reg      <= '0;
            withheld_reg  <= '0;
            ev_valid_reg  <= 1'b0;
            pay_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < BUTTONS; b++)
            begin
                since_reg[b] <= '0;
                left_reg[b]  <= '0;
            end
        end
        else
        begin
            held_reg      <= held_next;
            seen_reg      <= seen_next;
            withheld_reg  <= withheld_next;
            ev_valid_reg  <= ev_valid_next;
            pay_mask_reg  <= pay_mask_next;
            out_valid_reg <= out_valid_next;
            since_reg     <= since_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_button_reg   <= ev_button_next;
        ev_release_reg  <= ev_release_next;
        out_button_reg  <= out_button_next;
        out_release_reg <= out_release_next;
        out_delayed_reg <= out_delayed_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mbbf_pkg::TDATA_W - mbbf_pkg::BTN_W){1'b0}}, out_button_reg};
    assign m_tuser  = {out_delayed_reg, out_release_reg};
    assign m_tlast  = out_last_reg;

    // a bundle carries either a plain event or paid-back releases, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ev_valid_reg && (|pay_mask_reg)))
        else $error("bundle holds event and paid-back mask together");

    // a paid-back word is always a release
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("delayed word is not a release");

    // a flush leaves no button held or withheld
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action == mbbf_pkg::ACT_FLUSH)) |=>
            ((withheld_reg == '0) && (held_reg == '0) && (seen_reg == '0)))
        else $error("state not cleared after flush");

    // input stalls only while words are still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> pending)
        else $error("input stalled with nothing pending");

endmodule

>>> tb/sv/mouse_button_bounce_filter_unit_test.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the mouse button bounce filter unit

module mouse_button_bounce_filter_unit_test;

    localparam int NUM_BTN     = 3;
    localparam int DRAIN_PAD   = 8;
    localparam int STUCK_LIMIT = 4000;
    localparam int STALL_LEN   = 300;
    localparam int PHASE_ITEMS = 40;
    localparam int PILE_ITEMS  = 20;

    // one output word as the filter should emit it
    typedef struct packed {
        logic [1:0] btn;
        logic       rel;
        logic       del;
        logic       last;
    } event_word_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  act;
        logic [1:0]  btn;
        int          reps;
        bit          typed;
        int          n_typed;
        event_word_t word;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
    } script_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [mbbf_pkg::TDATA_W-1:0]  s_tdata;   // [1:0] button, rest zero
    logic [mbbf_pkg::ACTION_W-1:0] s_tuser;   // [1:0] action
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mbbf_pkg::TDATA_W-1:0]  m_tdata;   // [1:0] out_button, rest zero
    logic [1:0]                    m_tuser;   // [0] is_release, [1] delayed
    logic                          m_tlast;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mbbf_pkg::ADDR_W-1:0]   paddr;
    logic [mbbf_pkg::DATA_W-1:0]   pwdata;
    logic [mbbf_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // filter state mirror
    logic        held_dn    [NUM_BTN];
    logic        seen_press [NUM_BTN];
    logic [15:0] since_cnt  [NUM_BTN];
    logic        withheld   [NUM_BTN];
    logic [15:0] hold_cnt   [NUM_BTN];
    logic [15:0] cfg_short;
    logic [15:0] cfg_hold;
    logic [2:0]  cfg_enable;

    event_word_t due_words[$];
    script_row_t script[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        stall_kick = 1'b0;
    int          stall_left = 0;
    int          stuck_cycles = 0;

    mouse_button_bounce_filter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic event_word_t make_word(logic [1:0] b, logic rel, logic del);
        event_word_t w;
        w.btn  = b;
        w.rel  = rel;
        w.del  = del;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic void add_item(logic [1:0] act, logic [1:0] btn, int reps);
        script_row_t r;
        r.kind    = ROW_ITEM;
        r.act     = act;
        r.btn     = btn;
        r.reps    = reps;
        r.typed   = 1'b0;
        r.n_typed = 0;
        r.word    = '0;
        r.reg_idx = mbbf_pkg::REG_SHORT;
        r.reg_val = '0;
        script.push_back(r);
    endfunction

    // row whose outcome is written out by hand: no word or exactly one word
    function automatic void add_typed(logic [1:0] act, logic [1:0] btn, int n,
                                      logic [1:0] ob, logic rel, logic del);
        script_row_t r;
        r.kind    = ROW_ITEM;
        r.act     = act;
        r.btn     = btn;
        r.reps    = 1;
        r.typed   = 1'b1;
        r.n_typed = n;
        r.word    = make_word(ob, rel, del);
        r.reg_idx = mbbf_pkg::REG_SHORT;
        r.reg_val = '0;
        script.push_back(r);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [31:0] val);
        script_row_t r;
        r.kind    = ROW_REG;
        r.act     = mbbf_pkg::ACT_TICK;
        r.btn     = 2'd0;
        r.reps    = 0;
        r.typed   = 1'b0;
        r.n_typed = 0;
        r.word    = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        script.push_back(r);
    endfunction

    // next-state and emitted words of the filter for one item
    task automatic debounce_predict(input logic [1:0] act, input logic [1:0] btn,
                                    output event_word_t words [0:2], output int n);
        int b;
        n = 0;
        for (b = 0; b < 3; b++)
            words[b] = '0;
        if (act == mbbf_pkg::ACT_TICK)
        begin
            for (b = 0; b < NUM_BTN; b++)
            begin
                if (seen_press[b] && since_cnt[b] != 16'hFFFF)
                    since_cnt[b] = since_cnt[b] + 16'd1;
                if (withheld[b])
                begin
                    if (hold_cnt[b] <= 16'd1)
                    begin
                        withheld[b] = 1'b0;
                        hold_cnt[b] = '0;
                        held_dn[b]  = 1'b0;
                        words[n]    = make_word(2'(b), 1'b1, 1'b1);
                        n++;
                    end
                    else
                        hold_cnt[b] = hold_cnt[b] - 16'd1;
                end
            end
        end
        else if (act == mbbf_pkg::ACT_FLUSH)
        begin
            for (b = 0; b < NUM_BTN; b++)
            begin
                if (withheld[b])
                begin
                    words[n] = make_word(2'(b), 1'b1, 1'b1);
                    n++;
                end
                held_dn[b]    = 1'b0;
                seen_press[b] = 1'b0;
                since_cnt[b]  = '0;
                withheld[b]   = 1'b0;
                hold_cnt[b]   = '0;
            end
        end
        else if (btn >= NUM_BTN || !cfg_enable[btn])
        begin
            // out of range or unfiltered: straight through
            words[n] = make_word(btn, act == mbbf_pkg::ACT_RELEASE, 1'b0);
            n++;
        end
        else
        begin
            b = int'(btn);
            if (act == mbbf_pkg::ACT_PRESS)
            begin
                if (withheld[b])
                begin
                    withheld[b] = 1'b0;
                    hold_cnt[b] = '0;
                end
                else if (!held_dn[b])
                begin
                    held_dn[b] = 1'b1;
                    words[n]   = make_word(btn, 1'b0, 1'b0);
                    n++;
                end
                seen_press[b] = 1'b1;
                since_cnt[b]  = '0;
            end
            else if (!held_dn[b])
            begin
                words[n] = make_word(btn, 1'b1, 1'b0);
                n++;
            end
            else if (seen_press[b] && since_cnt[b] < cfg_short)
            begin
                withheld[b] = 1'b1;
                hold_cnt[b] = cfg_hold;
            end
            else
            begin
                held_dn[b] = 1'b0;
                words[n]   = make_word(btn, 1'b1, 1'b0);
                n++;
            end
        end
        for (b = 0; b < 3; b++)
            words[b].last = (b == n - 1);
    endtask

    // offer one word on the input stream until it is taken
    task automatic send_word(logic [1:0] act, logic [1:0] btn);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(mbbf_pkg::TDATA_W-2){1'b0}}, btn};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic issue(logic [1:0] act, logic [1:0] btn,
                         bit typed = 1'b0, int n_typed = 0, event_word_t tw = '0);
        event_word_t words [0:2];
        int          n;
        int          i;
        send_word(act, btn);
        items_sent++;
        debounce_predict(act, btn, words, n);
        if (typed)
        begin
            if (n_typed > 0)
                due_words.push_back(tw);
        end
        else
            for (i = 0; i < n; i++)
                due_words.push_back(words[i]);
    endtask

    // stop sending and let every expected word come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mbbf_pkg::REG_SHORT:  cfg_short  = val[15:0];
            mbbf_pkg::REG_HOLD:   cfg_hold   = val[15:0];
            mbbf_pkg::REG_ENABLE: cfg_enable = val[2:0];
            default: ;
        endcase
    endtask

    task automatic random_ticks(int max_n);
        int k;
        k = $urandom_range(0, max_n);
        repeat (k) issue(mbbf_pkg::ACT_TICK, 2'($urandom_range(0, 3)));
    endtask

    // press, short or long hold, release, sometimes a bounce back
    task automatic gesture();
        logic [1:0] b;
        b = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        issue(mbbf_pkg::ACT_PRESS, b);
        random_ticks(12);
        issue(mbbf_pkg::ACT_RELEASE, b);
        if ($urandom_range(0, 2) == 0)
        begin
            random_ticks(10);
            issue(mbbf_pkg::ACT_PRESS, b);
        end
        random_ticks(12);
    endtask

    task automatic noise_item();
        logic [1:0] act;
        act = 2'($urandom_range(0, 3));
        if (act == mbbf_pkg::ACT_FLUSH && $urandom_range(0, 3) != 0)
            act = mbbf_pkg::ACT_TICK;
        issue(act, 2'($urandom_range(0, 3)));
    endtask

    task automatic random_phase(int goal);
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) < 7)
                gesture();
            else
                noise_item();
        end
    endtask

    // receiver side: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        if (stall_kick)
            stall_left <= STALL_LEN;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        m_tready <= !stall_kick && stall_left == 0 && $urandom_range(0, 99) >= rx_idle_pct;
    end

    // compare each output word with the oldest expected one
    always @(posedge clk)
    begin
        event_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_words.size() == 0)
            begin
                $display("%0t: unexpected word btn %0d rel %0d del %0d last %0d",
                         $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                fail_count++;
            end
            else
            begin
                want = due_words.pop_front();
                if (m_tdata !== {{(mbbf_pkg::TDATA_W-2){1'b0}}, want.btn})
                begin
                    $display("%0t: out_button expected %0d got %0d", $time, want.btn, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.rel)
                begin
                    $display("%0t: is_release expected %0d got %0d", $time, want.rel, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== want.del)
                begin
                    $display("%0t: delayed expected %0d got %0d", $time, want.del, m_tuser[1]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last expected %0d got %0d", $time, want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int p;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = mbbf_pkg::ACT_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_short  = mbbf_pkg::SHORT_RST;
        cfg_hold   = mbbf_pkg::HOLD_RST;
        cfg_enable = mbbf_pkg::ENABLE_RST;
        for (i = 0; i < NUM_BTN; i++)
        begin
            held_dn[i]    = 1'b0;
            seen_press[i] = 1'b0;
            since_cnt[i]  = '0;
            withheld[i]   = 1'b0;
            hold_cnt[i]   = '0;
        end

        // directed script, reset register values first
        add_typed(mbbf_pkg::ACT_PRESS,   2'd0, 1, 2'd0, 1'b0, 1'b0);
        add_typed(mbbf_pkg::ACT_RELEASE, 2'd0, 0, 2'd0, 1'b0, 1'b0);   // too soon: withheld
        add_typed(mbbf_pkg::ACT_PRESS,   2'd0, 0, 2'd0, 1'b0, 1'b0);   // bounce cancels it
        add_typed(mbbf_pkg::ACT_PRESS,   2'd0, 0, 2'd0, 1'b0, 1'b0);   // repeated press swallowed
        add_typed(mbbf_pkg::ACT_RELEASE, 2'd0, 0, 2'd0, 1'b0, 1'b0);
        add_typed(mbbf_pkg::ACT_RELEASE, 2'd0, 0, 2'd0, 1'b0, 1'b0);   // replaces withheld release
        add_item(mbbf_pkg::ACT_TICK, 2'd1, 69);
        add_typed(mbbf_pkg::ACT_TICK,    2'd2, 1, 2'd0, 1'b1, 1'b1);   // hold time runs out
        add_typed(mbbf_pkg::ACT_PRESS,   2'd1, 1, 2'd1, 1'b0, 1'b0);   // disabled button
        add_typed(mbbf_pkg::ACT_RELEASE, 2'd3, 1, 2'd3, 1'b1, 1'b0);   // button out of range
        add_typed(mbbf_pkg::ACT_PRESS,   2'd3, 1, 2'd3, 1'b0, 1'b0);
        add_typed(mbbf_pkg::ACT_RELEASE, 2'd0, 1, 2'd0, 1'b1, 1'b0);   // unmatched release
        add_typed(mbbf_pkg::ACT_FLUSH,   2'd3, 0, 2'd0, 1'b0, 1'b0);
        // all buttons, widest thresholds, flush pays back three
        add_reg(mbbf_pkg::REG_ENABLE, 32'd7);
        add_reg(mbbf_pkg::REG_SHORT, 32'hFFFF);
        add_reg(mbbf_pkg::REG_HOLD, 32'hFFFF);
        for (i = 0; i < 3; i++)
            add_item(mbbf_pkg::ACT_PRESS, 2'(i), 1);
        for (i = 0; i < 3; i++)
            add_item(mbbf_pkg::ACT_RELEASE, 2'(i), 1);
        add_item(mbbf_pkg::ACT_TICK, 2'd3, 5);
        add_item(mbbf_pkg::ACT_FLUSH, 2'd0, 1);
        // zero short threshold: nothing is suspicious
        add_reg(mbbf_pkg::REG_SHORT, 32'd0);
        add_reg(mbbf_pkg::REG_HOLD, 32'd1);
        add_item(mbbf_pkg::ACT_PRESS, 2'd2, 1);
        add_item(mbbf_pkg::ACT_RELEASE, 2'd2, 1);
        // long release while another button holds one back
        add_reg(mbbf_pkg::REG_SHORT, 32'd1);
        add_reg(mbbf_pkg::REG_HOLD, 32'd2);
        add_item(mbbf_pkg::ACT_PRESS, 2'd0, 1);
        add_item(mbbf_pkg::ACT_RELEASE, 2'd0, 1);
        add_item(mbbf_pkg::ACT_PRESS, 2'd2, 1);
        add_item(mbbf_pkg::ACT_TICK, 2'd0, 1);
        add_item(mbbf_pkg::ACT_RELEASE, 2'd2, 1);
        add_item(mbbf_pkg::ACT_TICK, 2'd0, 1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 11;
        rx_idle_pct = 81;
        foreach (script[r])
        begin
            if (script[r].kind == ROW_REG)
            begin
                drain_results();
                write_reg(script[r].reg_idx, script[r].reg_val);
            end
            else
                for (i = 0; i < script[r].reps; i++)
                    issue(script[r].act, script[r].btn, script[r].typed,
                          script[r].n_typed, script[r].word);
        end

        // random phases, each with its own register setting and idling
        items_sent = 0;
        for (p = 0; p < 3; p++)
        begin
            drain_results();
            write_reg(mbbf_pkg::REG_SHORT, 32'($urandom_range(1, 10)));
            write_reg(mbbf_pkg::REG_HOLD, (p == 2) ? 32'd1 : 32'($urandom_range(1, 8)));
            write_reg(mbbf_pkg::REG_ENABLE, (p == 1) ? 32'($urandom_range(0, 7)) : 32'd7);
            tx_idle_pct = (p == 0) ? 11 : (p == 1) ? 81 : 0;
            rx_idle_pct = (p == 0) ? 81 : (p == 1) ? 11 : 0;
            if (p == 0)
            begin
                random_phase(PHASE_ITEMS / 2);
                drain_results();
            end
            if (p == 2)
            begin
                // receiver holds off while pass-through words pile up
                stall_kick <= 1'b1;
                @(posedge clk);
                stall_kick <= 1'b0;
                for (i = 0; i < PILE_ITEMS; i++)
                    issue((i % 2) ? mbbf_pkg::ACT_RELEASE : mbbf_pkg::ACT_PRESS, 2'd3);
            end
            random_phase((p + 1) * PHASE_ITEMS);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
